>>> sv/bdq_pkg.sv
package bdq_pkg;

	// Button count; the last button is the encoder push button
	localparam int NUM_BUTTONS = 7;
	localparam int LEVEL_W     = 7;
	localparam int CFG_W       = 16;
	localparam int CODE_W      = 4;
	localparam int KNOB_IDX    = NUM_BUTTONS - 1;

	// Event slots of one sample: buttons, then short, hold, cw, ccw
	localparam int EVT_SHORT = NUM_BUTTONS;
	localparam int EVT_HOLD  = NUM_BUTTONS + 1;
	localparam int EVT_CW    = NUM_BUTTONS + 2;
	localparam int EVT_CCW   = NUM_BUTTONS + 3;
	localparam int NUM_EVT   = NUM_BUTTONS + 4;

	localparam logic [CODE_W-1:0] CODE_SHORT = CODE_W'(EVT_SHORT);
	localparam logic [CODE_W-1:0] CODE_CCW   = CODE_W'(EVT_CCW);

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_HOLD       = 3'd1,
		REG_ACTIVE_LOW = 3'd2,
		REG_BTN_EN     = 3'd3,
		REG_ENC_EN     = 3'd4
	} cfg_reg_t;

	// 4x quadrature step table, index {previous AB, current AB}
	localparam logic signed [1:0] QUAD_STEP [16] = '{
		2'sd0,  -2'sd1, 2'sd1,  2'sd0,
		2'sd1,  2'sd0,  2'sd0,  -2'sd1,
		-2'sd1, 2'sd0,  2'sd0,  2'sd1,
		2'sd0,  2'sd1,  -2'sd1, 2'sd0
	};

	// Events caused by one sample
	typedef struct packed {
		logic [NUM_EVT-1:0]     mask;
		logic [NUM_BUTTONS-1:0] pressed;
	} bdq_rec_t;

	typedef struct packed {
		logic push;
		logic primed;
	} bdq_front_stat_t;

	typedef struct packed {
		logic empty;
		logic full;
	} bdq_queue_stat_t;

endpackage

>>> sv/bdq_front.sv
module bdq_front import bdq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 take,
	input  logic [LEVEL_W-1:0]   button_levels,
	input  logic                 phase_a,
	input  logic                 phase_b,
	input  logic [31:0]          now_tick,
	output bdq_rec_t             rec,
	output bdq_front_stat_t      stat
);

	// Configuration registers
	logic [7:0]             debounce_q;
	logic [15:0]            hold_ticks_q;
	logic                   active_low_q;
	logic [NUM_BUTTONS-1:0] btn_en_q;
	logic                   enc_en_q;

	// Sample state
	logic                   primed_q;
	logic [NUM_BUTTONS-1:0] stable_q;
	logic [7:0]             cnt_q [NUM_BUTTONS];
	logic                   knob_q;
	logic                   hold_rep_q;
	logic [31:0]            press_time_q;
	logic [1:0]             prev_ab_q;
	logic signed [2:0]      acc_q;

	// Next-state values
	logic [NUM_BUTTONS-1:0] lvl;
	logic [NUM_BUTTONS-1:0] differ;
	logic [NUM_BUTTONS-1:0] flip;
	logic [NUM_BUTTONS-1:0] stable_d;
	logic [NUM_BUTTONS-1:0] prime_d;
	logic [NUM_BUTTONS-1:0] pr;
	logic [7:0]             cnt_inc [NUM_BUTTONS];
	logic [7:0]             cnt_d [NUM_BUTTONS];
	logic                   knob_ev;
	logic                   short_ev;
	logic                   hold_ev;
	logic                   knob_d;
	logic                   hold_mid;
	logic [31:0]            press_time_d;
	logic [31:0]            dt;
	logic [1:0]             ab;
	logic signed [1:0]      step;
	logic signed [3:0]      sum;
	logic                   moved;
	logic                   cw_ev;
	logic                   ccw_ev;
	logic signed [2:0]      acc_d;

	// Debounce every button independently
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			lvl[i]     = (i < LEVEL_W) ? button_levels[i % LEVEL_W] : 1'b0;
			differ[i]  = lvl[i] ^ stable_q[i];
			cnt_inc[i] = cnt_q[i] + 8'd1;
			flip[i]    = btn_en_q[i] && differ[i] && (cnt_inc[i] >= debounce_q);
			if (!btn_en_q[i]) begin
				cnt_d[i] = cnt_q[i];
			end else if (differ[i] && !flip[i]) begin
				cnt_d[i] = cnt_inc[i];
			end else begin
				cnt_d[i] = 8'd0;
			end
			stable_d[i] = stable_q[i] ^ flip[i];
			prime_d[i]  = btn_en_q[i] ? lvl[i] : stable_q[i];
			pr[i]       = stable_d[i] ^ active_low_q;
		end
	end

	// Encoder button: short press on release, hold after hold_ticks
	always_comb begin
		knob_ev      = flip[KNOB_IDX];
		short_ev     = knob_ev && !pr[KNOB_IDX] && knob_q && !hold_rep_q;
		knob_d       = knob_ev ? pr[KNOB_IDX] : knob_q;
		hold_mid     = knob_ev ? 1'b0 : hold_rep_q;
		press_time_d = (knob_ev && pr[KNOB_IDX]) ? now_tick : press_time_q;
		dt           = now_tick - press_time_d;
		hold_ev      = knob_d && !hold_mid && (dt >= {16'd0, hold_ticks_q});
	end

	// Quadrature step and accumulate
	always_comb begin
		ab     = {phase_a ^ active_low_q, phase_b ^ active_low_q};
		step   = QUAD_STEP[{prev_ab_q, ab}];
		sum    = {acc_q[2], acc_q} + {{2{step[1]}}, step};
		moved  = enc_en_q && (step != 2'sd0);
		cw_ev  = moved && (sum >= 4'sd4);
		ccw_ev = moved && (sum <= -4'sd4);
		if (!moved) begin
			acc_d = acc_q;
		end else if (cw_ev || ccw_ev) begin
			acc_d = 3'sd0;
		end else begin
			acc_d = sum[2:0];
		end
	end

	// Record of this sample's events
	always_comb begin
		rec.mask    = {ccw_ev, cw_ev, hold_ev, short_ev, flip};
		rec.pressed = pr;
		stat.push   = take && primed_q && (rec.mask != '0);
		stat.primed = primed_q;
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= 8'd3;
			hold_ticks_q <= 16'd100;
			active_low_q <= 1'b1;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				btn_en_q[i] <= (i < LEVEL_W);
			end
			enc_en_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_wdata[7:0];
				REG_HOLD:       hold_ticks_q <= cfg_wdata[15:0];
				REG_ACTIVE_LOW: active_low_q <= cfg_wdata[0];
				REG_BTN_EN: begin
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						btn_en_q[i] <= (i < LEVEL_W) ? cfg_wdata[i % CFG_W] : 1'b0;
					end
				end
				REG_ENC_EN:     enc_en_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Advance sample state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			stable_q     <= '1;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= 8'd0;
			end
			knob_q       <= 1'b0;
			hold_rep_q   <= 1'b0;
			press_time_q <= 32'd0;
			prev_ab_q    <= 2'd0;
			acc_q        <= 3'sd0;
		end else if (take) begin
			if (!primed_q) begin
				primed_q <= 1'b1;
				stable_q <= prime_d;
				if (enc_en_q) begin
					prev_ab_q <= ab;
				end
			end else begin
				stable_q     <= stable_d;
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					cnt_q[i] <= cnt_d[i];
				end
				knob_q       <= knob_d;
				hold_rep_q   <= hold_mid | hold_ev;
				press_time_q <= press_time_d;
				if (enc_en_q) begin
					prev_ab_q <= ab;
				end
				acc_q        <= acc_d;
			end
		end
	end

endmodule

>>> sv/bdq_queue.sv
module bdq_queue import bdq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bdq_rec_t        push_rec,
	input  logic            pop,
	output bdq_rec_t        head,
	output bdq_queue_stat_t stat
);

	bdq_rec_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_comb begin
		head       = mem_q[rd_ptr_q];
		stat.empty = (count_q == '0);
		stat.full  = (count_q == QCNT_W'(QDEPTH));
	end

	// Store pushed records
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/bdq_back.sv
module bdq_back import bdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bdq_rec_t          head,
	input  bdq_queue_stat_t   qstat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CODE_W-1:0] event_code,
	output logic              pressed,
	output logic              last_event
);

	logic [NUM_EVT-1:0]     cur_mask_q;
	logic [NUM_BUTTONS-1:0] cur_pr_q;
	logic                   valid_q;
	logic [CODE_W-1:0]      code_q;
	logic                   pressed_q;
	logic                   last_q;

	logic [NUM_EVT-1:0]     lowest;
	logic [NUM_EVT-1:0]     rest;
	logic [CODE_W-1:0]      code_sel;
	logic                   pr_sel;
	logic                   out_free;
	logic                   emit;

	// Pick the lowest pending event
	always_comb begin
		lowest   = cur_mask_q & (~cur_mask_q + 1'b1);
		rest     = cur_mask_q & ~lowest;
		code_sel = '0;
		for (int i = 0; i < NUM_EVT; i++) begin
			if (lowest[i]) begin
				code_sel = code_sel | CODE_W'(i);
			end
		end
		pr_sel   = (|(lowest[NUM_BUTTONS-1:0] & cur_pr_q))
		         | (|lowest[NUM_EVT-1:NUM_BUTTONS]);
		out_free = !valid_q || out_ready;
		emit     = out_free && (cur_mask_q != '0);
		pop      = (cur_mask_q == '0) && !qstat.empty;
	end

	// Load a record or drop the event just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q <= '0;
		end else if (pop) begin
			cur_mask_q <= head.mask;
		end else if (emit) begin
			cur_mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_pr_q <= head.pressed;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_q    <= code_sel;
			pressed_q <= pr_sel;
			last_q    <= (rest == '0);
		end
	end

	assign out_valid  = valid_q;
	assign event_code = code_q;
	assign pressed    = pressed_q;
	assign last_event = last_q;

endmodule

>>> sv/button_debounce_quadrature_decoder.sv
// A sample's first event passes the event queue, the record register and the
// output register. One sample beat per cycle while the 2-deep event queue has
// room; the output side sends one event per cycle while out_ready allows and
// loads a record only after the last event of the one before is sent.
// Reset (arst_n low, asynchronous): control and configuration state are reset;
// the first sample after reset primes levels and phases and emits nothing.
module button_debounce_quadrature_decoder import bdq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LEVEL_W-1:0] button_levels,
	input  logic               phase_a,
	input  logic               phase_b,
	input  logic [31:0]        now_tick,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CODE_W-1:0]  event_code,
	output logic               pressed,
	output logic               last_event
);

	logic            take;
	bdq_rec_t        rec;
	bdq_front_stat_t fstat;
	bdq_rec_t        head;
	bdq_queue_stat_t qstat;
	logic            pop;

	assign in_ready = !qstat.full;
	assign take     = in_valid && in_ready;

	bdq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.take          (take),
		.button_levels (button_levels),
		.phase_a       (phase_a),
		.phase_b       (phase_b),
		.now_tick      (now_tick),
		.rec           (rec),
		.stat          (fstat)
	);

	bdq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fstat.push),
		.push_rec (rec),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	bdq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.pressed    (pressed),
		.last_event (last_event)
	);

	// The priming sample never queues events
	a_prime_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !fstat.primed) |-> !fstat.push)
		else $error("events queued by priming sample");

	// Clockwise and counterclockwise never share a sample
	a_dir_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.push |-> !(rec.mask[EVT_CW] && rec.mask[EVT_CCW]))
		else $error("both rotation directions in one sample");

	// Only defined event codes leave the block
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code <= CODE_CCW))
		else $error("event code out of range");

	// Short, hold and rotation events are always presses
	a_pressed_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_code >= CODE_SHORT)) |-> pressed)
		else $error("non-button event not marked pressed");

endmodule

>>> tb/tb_button_debounce_quadrature_decoder.sv
`timescale 1ns / 1ps

module tb_button_debounce_quadrature_decoder;
	import bdq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 10;
	localparam int DETENT_STEPS  = 4;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	// Step per {previous AB, current AB}; +1 follows 00 -> 10 -> 11 -> 01
	localparam int QUAD_DELTA [16] = '{
		0, -1, 1, 0,
		1, 0, 0, -1,
		-1, 0, 0, 1,
		0, 1, -1, 0
	};
	localparam logic [1:0] GRAY_AB [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

	typedef struct packed {
		logic [LEVEL_W-1:0] levels;
		logic               a;
		logic               b;
		logic [31:0]        tick;
	} poll_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              pressed;
		logic              last;
	} ev_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [LEVEL_W-1:0] button_levels = '0;
	logic               phase_a = 1'b0;
	logic               phase_b = 1'b0;
	logic [31:0]        now_tick = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CODE_W-1:0]  event_code;
	logic               pressed;
	logic               last_event;

	// Predictor copy of the registers
	logic [7:0]             deb_len = 8'd3;
	logic [15:0]            hold_len = 16'd100;
	logic                   inv_pol = 1'b1;
	logic [NUM_BUTTONS-1:0] btn_used = '1;
	logic                   enc_used = 1'b1;

	// Predictor copy of the state
	logic                   primed = 1'b0;
	logic [NUM_BUTTONS-1:0] stable_lv = '1;
	logic [NUM_BUTTONS-1:0] shown_lv = '1;
	logic [7:0]             bounce_cnt [NUM_BUTTONS] = '{default: 8'd0};
	logic                   knob_down = 1'b0;
	logic                   hold_done = 1'b0;
	logic [31:0]            knob_tick = '0;
	logic [1:0]             prev_ab = 2'b00;
	int                     step_sum = 0;

	poll_t poll_queue [$];
	ev_t   awaited_events [$];

	int          mismatches = 0;
	int          tx_gap = 0;
	int          rx_stall = 0;
	int          tx_gap_pct = 0;
	int          rx_stall_pct = 0;
	int unsigned cycles = 0;

	// Random walk state for the sample generator
	logic [LEVEL_W-1:0] rnd_levels = '1;
	int                 rnd_pos = 0;
	int                 rnd_dir = 1;
	logic [31:0]        rnd_tick = 32'd300;

	button_debounce_quadrature_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.button_levels (button_levels),
		.phase_a       (phase_a),
		.phase_b       (phase_b),
		.now_tick      (now_tick),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_code    (event_code),
		.pressed       (pressed),
		.last_event    (last_event)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_error(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", what);
	endfunction

	// Gap with probability pct percent: mostly short, rarely long
	function automatic int pick_gap(int pct);
		int r;
		if ($urandom_range(99) >= pct)
			return 0;
		r = $urandom_range(99);
		if (r < 85)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic ev_t make_ev(int code, logic pr);
		ev_t e;
		e.code = CODE_W'(code);
		e.pressed = pr;
		e.last = 1'b0;
		return e;
	endfunction

	// Work out the events one sample causes and queue them
	function automatic void predict_events(poll_t s);
		ev_t evs [$];
		logic [1:0] ab;
		logic [31:0] dt;
		logic pr;
		int d;
		int n;
		ab = {s.a ^ inv_pol, s.b ^ inv_pol};
		if (!primed) begin
			stable_lv = (stable_lv & ~btn_used) | (s.levels & btn_used);
			shown_lv = (shown_lv & ~btn_used) | (s.levels & btn_used);
			if (enc_used)
				prev_ab = ab;
			primed = 1'b1;
			return;
		end
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (btn_used[i]) begin
				// Count differing samples, accept the new level at the limit
				if (s.levels[i] != stable_lv[i]) begin
					bounce_cnt[i] = bounce_cnt[i] + 8'd1;
					if (bounce_cnt[i] >= deb_len) begin
						stable_lv[i] = s.levels[i];
						bounce_cnt[i] = 8'd0;
					end
				end else begin
					bounce_cnt[i] = 8'd0;
				end
				if (stable_lv[i] != shown_lv[i]) begin
					pr = inv_pol ? ~stable_lv[i] : stable_lv[i];
					evs.push_back(make_ev(i, pr));
					if (i == KNOB_IDX) begin
						if (pr) begin
							knob_down = 1'b1;
							knob_tick = s.tick;
							hold_done = 1'b0;
						end else begin
							if (knob_down && !hold_done)
								evs.push_back(make_ev(EVT_SHORT, 1'b1));
							knob_down = 1'b0;
							hold_done = 1'b0;
						end
					end
					shown_lv[i] = stable_lv[i];
				end
			end
		end
		// Hold fires once, tick difference wraps
		if (knob_down && !hold_done) begin
			dt = s.tick - knob_tick;
			if (dt >= 32'(hold_len)) begin
				evs.push_back(make_ev(EVT_HOLD, 1'b1));
				hold_done = 1'b1;
			end
		end
		if (enc_used) begin
			d = QUAD_DELTA[{prev_ab, ab}];
			prev_ab = ab;
			if (d != 0) begin
				step_sum += d;
				if (step_sum >= DETENT_STEPS) begin
					evs.push_back(make_ev(EVT_CW, 1'b1));
					step_sum = 0;
				end else if (step_sum <= -DETENT_STEPS) begin
					evs.push_back(make_ev(EVT_CCW, 1'b1));
					step_sum = 0;
				end
			end
		end
		n = evs.size();
		if (n > 0)
			evs[n-1].last = 1'b1;
		foreach (evs[k])
			awaited_events.push_back(evs[k]);
	endfunction

	// Sample driver: hold the beat until accepted, then maybe idle
	always @(posedge clk) begin : drive_samples
		poll_t s;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_events(poll_t'({button_levels, phase_a, phase_b, now_tick}));
			if (!in_valid || in_ready) begin
				if (tx_gap > 0 || poll_queue.size() == 0) begin
					if (tx_gap > 0)
						tx_gap--;
					in_valid <= 1'b0;
				end else begin
					s = poll_queue.pop_front();
					button_levels <= s.levels;
					phase_a <= s.a;
					phase_b <= s.b;
					now_tick <= s.tick;
					in_valid <= 1'b1;
					tx_gap = pick_gap(tx_gap_pct);
				end
			end
		end
	end

	// Event monitor: compare each beat with the oldest expectation
	always @(posedge clk) begin : check_events
		ev_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_events.size() == 0) begin
					note_error($sformatf("unexpected event: code %0d pressed %0b last %0b",
						event_code, pressed, last_event));
				end else begin
					want = awaited_events.pop_front();
					if (event_code !== want.code || pressed !== want.pressed ||
						last_event !== want.last)
						note_error($sformatf(
							"event mismatch: expected code %0d pressed %0b last %0b, got %0d %0b %0b",
							want.code, want.pressed, want.last, event_code, pressed, last_event));
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_stall = pick_gap(rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic add_poll(logic [LEVEL_W-1:0] levels, logic a, logic b, logic [31:0] tick);
		poll_t s;
		s.levels = levels;
		s.a = a;
		s.b = b;
		s.tick = tick;
		poll_queue.push_back(s);
	endtask

	// Mostly slow button changes, glitches and a knob turning, some noise
	task automatic add_random(int count);
		poll_t s;
		logic [1:0] ab;
		int pick;
		int k;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				k = $urandom_range(NUM_BUTTONS - 1);
				rnd_levels[k] = ~rnd_levels[k];
			end else if (pick < 25) begin
				rnd_levels = LEVEL_W'($urandom);
			end
			s.levels = rnd_levels;
			if (pick >= 85)
				s.levels = rnd_levels ^ LEVEL_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 10)
				rnd_dir = -rnd_dir;
			if (pick < 70)
				rnd_pos = (rnd_pos + rnd_dir) & 3;
			else if (pick >= 90)
				rnd_pos = $urandom_range(3);
			ab = GRAY_AB[rnd_pos];
			s.a = ab[1] ^ inv_pol;
			s.b = ab[0] ^ inv_pol;
			pick = $urandom_range(99);
			if (pick < 70)
				rnd_tick += $urandom_range(15);
			else if (pick < 90)
				rnd_tick += $urandom_range(300, 16);
			else if (pick < 95)
				rnd_tick = $urandom;
			else
				rnd_tick = 32'hFFFF_FFFF - $urandom_range(20);
			s.tick = rnd_tick;
			poll_queue.push_back(s);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_DEBOUNCE:   deb_len = data[7:0];
			REG_HOLD:       hold_len = data[15:0];
			REG_ACTIVE_LOW: inv_pol = data[0];
			REG_BTN_EN:     btn_used = data[NUM_BUTTONS-1:0];
			REG_ENC_EN:     enc_used = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every sample and event, then let the block settle
	task automatic wait_drained();
		while (poll_queue.size() != 0 || in_valid || awaited_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_phase(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] hold,
		logic [CFG_W-1:0] pol, logic [CFG_W-1:0] used, logic [CFG_W-1:0] enc,
		int tx_pct, int rx_pct);
		wait_drained();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_HOLD, hold);
		write_reg(REG_ACTIVE_LOW, pol);
		write_reg(REG_BTN_EN, used);
		write_reg(REG_ENC_EN, enc);
		tx_gap_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Prime with one button disabled, then presses, holds and a full detent each way
		set_phase(16'd1, 16'd5, 16'd1, 16'h005F, 16'd1, 30, 30);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd0);
		add_poll(7'h00, 1'b1, 1'b1, 32'd1);
		add_poll(7'h00, 1'b1, 1'b1, 32'd3);
		add_poll(7'h00, 1'b1, 1'b1, 32'd6);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd7);
		add_poll(7'h3F, 1'b1, 1'b1, 32'hFFFF_FFFE);
		add_poll(7'h3F, 1'b1, 1'b1, 32'd3);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd4);
		add_poll(7'h3F, 1'b1, 1'b1, 32'd10);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd12);
		add_poll(7'h7F, 1'b0, 1'b1, 32'd13);
		add_poll(7'h7F, 1'b0, 1'b0, 32'd14);
		add_poll(7'h7F, 1'b1, 1'b0, 32'd15);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd16);
		add_poll(7'h7F, 1'b1, 1'b0, 32'd17);
		add_poll(7'h7F, 1'b0, 1'b0, 32'd18);
		add_poll(7'h7F, 1'b0, 1'b1, 32'd19);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd20);
		add_poll(7'h7F, 1'b0, 1'b0, 32'd21);
		add_poll(7'h40, 1'b1, 1'b1, 32'hFFFF_FFFF);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd0);

		// Zero debounce through masked write data, zero hold time, active high
		set_phase(16'hFF00, 16'd0, 16'd0, 16'h007F, 16'd1, 0, 0);
		add_poll(7'h00, 1'b1, 1'b0, 32'd100);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd101);
		add_poll(7'h7F, 1'b0, 1'b1, 32'd102);
		add_random(50);

		// Longest hold; release of every button with a short press and a detent
		set_phase(16'd2, 16'hFFFF, 16'd1, 16'h007F, 16'd1, 20, 40);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		add_poll(7'h00, 1'b1, 1'b0, 32'd200);
		add_poll(7'h00, 1'b1, 1'b0, 32'd201);
		add_poll(7'h7F, 1'b1, 1'b0, 32'd202);
		add_poll(7'h7F, 1'b1, 1'b1, 32'd203);
		add_random(45);

		// Encoder off and knob button off, some buttons frozen
		set_phase(16'd3, 16'd100, 16'd1, 16'hFF2A, 16'd0, 50, 10);
		add_random(50);

		// Longest debounce
		set_phase(16'd255, 16'd20, 16'hFFFE, 16'h007F, 16'd1, 0, 60);
		add_random(30);

		// Frozen buttons resume
		set_phase(16'd1, 16'd40, 16'd1, 16'h007F, 16'd1, 25, 25);
		add_random(70);

		set_phase(16'd2, 16'd0, 16'd0, 16'h0055, 16'd1, 60, 60);
		add_random(40);

		wait_drained();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
sv/bdq_pkg.sv
sv/bdq_front.sv
sv/bdq_queue.sv
sv/bdq_back.sv
sv/button_debounce_quadrature_decoder.sv
tb/tb_button_debounce_quadrature_decoder.sv
